[hw/rtl/packet_buffer_queue_defines.svh]
// Assertion macros shared by the packet buffer queue checkers.
`ifndef PACKET_BUFFER_QUEUE_DEFINES_SVH
`define PACKET_BUFFER_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define PBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define PBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pbq_pkg.sv]
// Types and constants of the packet buffer queue.
package pbq_pkg;

    // Port field widths.
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int ERR_W    = 4;
    localparam int STATE_W  = 7;
    localparam int OFFS_W   = 12;
    localparam int LEN_W    = 13;
    localparam int COUNT_W  = 9;

    // Packet state word bits.
    localparam logic [STATE_W-1:0] ST_PARTIAL = 7'd1;
    localparam logic [STATE_W-1:0] ST_FULL    = 7'd2;
    localparam logic [STATE_W-1:0] ST_PAYLOAD = 7'd4;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_FILL   = 2'd0,
        OP_CUT    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DROP,
        S_DROP_ORG,
        S_DROP_END,
        S_MV_RD,
        S_MV_WR,
        S_SH_RD,
        S_SH_WR,
        S_CR,
        S_CR_WR,
        S_FL_CHK,
        S_FL_UPD,
        S_CUT_RD,
        S_CUT_CHK,
        S_CUT_NEW,
        S_RD_DESC,
        S_RD_CHK,
        S_RD_BYTE,
        S_FIN,
        S_FIN_FIRST,
        S_FIN_LAST
    } state_t;

endpackage

[hw/rtl/pbq_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module pbq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read at a written address sees old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/packet_buffer_queue.sv]
// Top level of the packet buffer queue: sequencer over descriptor and byte memories.
//
// Usage: an item (operation and its fields) is taken at a clock edge where start
// is high and busy is low. busy stays high while the item is worked on; one
// result comes back on the result ports for a single cycle with done high, and
// busy is low again in that same cycle, so the next item may start there.
// The receiver cannot hold results off.
// Accesses are sequenced because each memory has a single read port. A read,
// cut or remove on an empty queue is refused.
// A remove (and a fill with create, or a cut no longer than the last packet,
// on a full queue) also runs the compaction: the B bytes behind the oldest
// packet and the descriptors of the N-1 later packets, N being the packet
// count, are moved down one at a time, each read and then written.
// Reset clears the packet count and the sequencer; the memories hold no reset
// value and need no clearing pass, since only written entries are ever read.
module packet_buffer_queue
    import pbq_pkg::*;
#(
    parameter int BUF_BYTES   = 4096,
    parameter int MAX_PACKETS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    operation,
    input  logic               cmd_create,
    input  logic               cmd_close,
    input  logic               has_byte,
    input  logic               byte_is_payload,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [ERR_W-1:0]   error_bits,
    input  logic [LEN_W-1:0]   cut_offset,
    input  logic [STATE_W-1:0] left_state,
    input  logic [STATE_W-1:0] right_state,
    input  logic [OFFS_W-1:0]  read_offset,
    output logic               done,
    output logic [STATE_W-1:0] status_word,
    output logic               rejected,
    output logic [COUNT_W-1:0] packet_count,
    output logic [STATE_W-1:0] last_state,
    output logic [STATE_W-1:0] first_state,
    output logic               has_first_packet,
    output logic [OFFS_W-1:0]  first_start,
    output logic [LEN_W-1:0]   first_len,
    output logic [OFFS_W-1:0]  first_payload_start,
    output logic [LEN_W-1:0]   first_payload_len,
    output logic [BYTE_W-1:0]  read_byte
);

    localparam int AW  = $clog2(BUF_BYTES);
    localparam int LW  = $clog2(BUF_BYTES + 1);
    localparam int CW  = $clog2(MAX_PACKETS + 1);
    localparam int DW  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int XW  = ((LW > LEN_W) ? LW : LEN_W) + 1;

    typedef struct packed {
        logic [LW-1:0]      start;
        logic [LW-1:0]      len;
        logic [LW-1:0]      pstart;
        logic [LW-1:0]      plen;
        logic [STATE_W-1:0] state;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    // Sequencer and bookkeeping registers.
    state_t        state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [LW-1:0] org_reg,    org_next;
    logic [LW-1:0] j_reg,      j_next;
    logic [LW-1:0] mvlen_reg,  mvlen_next;
    logic [DW-1:0] idx_reg,    idx_next;
    logic          rej_reg,    rej_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    desc_t         first_reg,  first_next;
    desc_t         split_reg,  split_next;
    logic          done_reg,   done_next;

    // Captured item fields.
    op_t                op_reg;
    logic               create_reg;
    logic               close_reg;
    logic               hasb_reg;
    logic               pay_reg;
    logic [BYTE_W-1:0]  dbyte_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [LEN_W-1:0]   cut_reg;
    logic [STATE_W-1:0] lst_reg;
    logic [STATE_W-1:0] rst_reg;
    logic [OFFS_W-1:0]  roff_reg;

    // Result registers.
    logic [STATE_W-1:0] status_word_reg,   status_word_next;
    logic               rejected_reg,      rejected_next;
    logic [COUNT_W-1:0] packet_count_reg,  packet_count_next;
    logic [STATE_W-1:0] last_state_reg,    last_state_next;
    logic [STATE_W-1:0] first_state_reg,   first_state_next;
    logic               has_first_reg,     has_first_next;
    logic [OFFS_W-1:0]  first_start_reg,   first_start_next;
    logic [LEN_W-1:0]   first_len_reg,     first_len_next;
    logic [OFFS_W-1:0]  first_pstart_reg,  first_pstart_next;
    logic [LEN_W-1:0]   first_plen_reg,    first_plen_next;
    logic [BYTE_W-1:0]  read_byte_reg,     read_byte_next;

    // Memory ports.
    logic              d_we;
    logic [DW-1:0]     d_waddr;
    desc_t             d_wdata;
    logic [DW-1:0]     d_raddr;
    desc_t             d_rdata;
    logic [DESC_W-1:0] d_rdata_raw;
    logic              b_we;
    logic [AW-1:0]     b_waddr;
    logic [BYTE_W-1:0] b_wdata;
    logic [AW-1:0]     b_raddr;
    logic [BYTE_W-1:0] b_rdata;

    // Working values.
    logic [DW-1:0]      last_idx;
    logic [CW-1:0]      count_m1;
    state_t             after_drop;
    desc_t              cur_d;
    desc_t              right_d;
    logic [XW-1:0]      sum_x;
    logic [STATE_W-1:0] left_bits;

    pbq_ram #(
        .WIDTH  (DESC_W),
        .DEPTH  (MAX_PACKETS),
        .ADDR_W (DW)
    ) u_desc_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata_raw)
    );

    assign d_rdata = desc_t'(d_rdata_raw);

    pbq_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (BUF_BYTES),
        .ADDR_W (AW)
    ) u_byte_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign count_m1  = count_reg - CW'(1);
    assign last_idx  = (count_reg == '0) ? '0 : DW'(count_m1);
    assign left_bits = lst_reg | ST_FULL;

    // Where the sequencer goes once the oldest packet is dropped.
    always_comb
    begin
        unique case (op_reg)
            OP_FILL:   after_drop = S_CR;
            OP_CUT:    after_drop = S_CUT_RD;
            default:   after_drop = S_FIN;
        endcase
    end

    // Capture the item fields on accept.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg     <= op_t'(operation);
            create_reg <= cmd_create;
            close_reg  <= cmd_close;
            hasb_reg   <= has_byte;
            pay_reg    <= byte_is_payload;
            dbyte_reg  <= data_byte;
            err_reg    <= error_bits;
            cut_reg    <= cut_offset;
            lst_reg    <= left_state;
            rst_reg    <= right_state;
            roff_reg   <= read_offset;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        org_reg          <= org_next;
        j_reg            <= j_next;
        mvlen_reg        <= mvlen_next;
        idx_reg          <= idx_next;
        rej_reg          <= rej_next;
        rbyte_reg        <= rbyte_next;
        first_reg        <= first_next;
        split_reg        <= split_next;
        status_word_reg  <= status_word_next;
        rejected_reg     <= rejected_next;
        packet_count_reg <= packet_count_next;
        last_state_reg   <= last_state_next;
        first_state_reg  <= first_state_next;
        has_first_reg    <= has_first_next;
        first_start_reg  <= first_start_next;
        first_len_reg    <= first_len_next;
        first_pstart_reg <= first_pstart_next;
        first_plen_reg   <= first_plen_next;
        read_byte_reg    <= read_byte_next;
    end

    // Next state, memory accesses and results.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        org_next          = org_reg;
        j_next            = j_reg;
        mvlen_next        = mvlen_reg;
        idx_next          = idx_reg;
        rej_next          = rej_reg;
        rbyte_next        = rbyte_reg;
        first_next        = first_reg;
        split_next        = split_reg;
        done_next         = 1'b0;
        status_word_next  = status_word_reg;
        rejected_next     = rejected_reg;
        packet_count_next = packet_count_reg;
        last_state_next   = last_state_reg;
        first_state_next  = first_state_reg;
        has_first_next    = has_first_reg;
        first_start_next  = first_start_reg;
        first_len_next    = first_len_reg;
        first_pstart_next = first_pstart_reg;
        first_plen_next   = first_plen_reg;
        read_byte_next    = read_byte_reg;
        d_we              = 1'b0;
        d_waddr           = '0;
        d_wdata           = '0;
        d_raddr           = '0;
        b_we              = 1'b0;
        b_waddr           = '0;
        b_wdata           = '0;
        b_raddr           = '0;
        cur_d             = d_rdata;
        right_d           = '0;
        sum_x             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rej_next   = 1'b0;
                    rbyte_next = '0;
                    unique case (op_t'(operation))
                        OP_FILL:
                        begin
                            if (!cmd_create)
                                state_next = S_FL_CHK;
                            else if (count_reg >= CW'(MAX_PACKETS))
                                state_next = S_DROP;
                            else
                                state_next = S_CR;
                        end
                        OP_CUT:
                        begin
                            if (count_reg == '0)
                            begin
                                rej_next   = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                                state_next = S_CUT_RD;
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rej_next   = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                                state_next = S_DROP;
                        end
                        OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                rej_next   = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                                state_next = S_RD_DESC;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            // Drop the oldest packet; a lone packet just goes away.
            S_DROP:
            begin
                if (count_reg == CW'(1))
                begin
                    count_next = '0;
                    state_next = after_drop;
                end
                else
                begin
                    d_raddr    = DW'(1);
                    state_next = S_DROP_ORG;
                end
            end

            S_DROP_ORG:
            begin
                org_next   = d_rdata.start;
                d_raddr    = last_idx;
                state_next = S_DROP_END;
            end

            // The end of the last packet bounds the bytes to move down.
            S_DROP_END:
            begin
                sum_x = XW'(d_rdata.start) + XW'(d_rdata.len);
                if (sum_x > XW'(org_reg) && sum_x <= XW'(BUF_BYTES))
                begin
                    mvlen_next = LW'(sum_x - XW'(org_reg));
                    j_next     = '0;
                    state_next = S_MV_RD;
                end
                else
                begin
                    idx_next   = DW'(1);
                    state_next = S_SH_RD;
                end
            end

            S_MV_RD:
            begin
                b_raddr    = AW'(org_reg + j_reg);
                state_next = S_MV_WR;
            end

            S_MV_WR:
            begin
                b_we    = 1'b1;
                b_waddr = AW'(j_reg);
                b_wdata = b_rdata;
                j_next  = j_reg + LW'(1);
                if (j_reg + LW'(1) == mvlen_reg)
                begin
                    idx_next   = DW'(1);
                    state_next = S_SH_RD;
                end
                else
                    state_next = S_MV_RD;
            end

            S_SH_RD:
            begin
                d_raddr    = idx_reg;
                state_next = S_SH_WR;
            end

            // Move one descriptor down a slot, rebased to the new origin.
            S_SH_WR:
            begin
                cur_d.start  = (d_rdata.start >= org_reg) ? d_rdata.start - org_reg : '0;
                cur_d.pstart = (d_rdata.pstart >= org_reg) ? d_rdata.pstart - org_reg : '0;
                d_we    = 1'b1;
                d_waddr = idx_reg - DW'(1);
                d_wdata = cur_d;
                idx_next = idx_reg + DW'(1);
                if (CW'(idx_reg) == count_m1)
                begin
                    count_next = count_m1;
                    state_next = after_drop;
                end
                else
                    state_next = S_SH_RD;
            end

            // Open a new partial packet right after the last one.
            S_CR:
            begin
                if (count_reg == '0)
                begin
                    right_d.state = ST_PARTIAL;
                    d_we       = 1'b1;
                    d_waddr    = '0;
                    d_wdata    = right_d;
                    count_next = CW'(1);
                    state_next = S_FL_CHK;
                end
                else
                begin
                    d_raddr    = last_idx;
                    state_next = S_CR_WR;
                end
            end

            S_CR_WR:
            begin
                right_d.start = LW'(d_rdata.start + d_rdata.len);
                right_d.state = ST_PARTIAL;
                d_we       = 1'b1;
                d_waddr    = DW'(count_reg);
                d_wdata    = right_d;
                count_next = count_reg + CW'(1);
                state_next = S_FL_CHK;
            end

            S_FL_CHK:
            begin
                if (!(hasb_reg || close_reg || err_reg != '0))
                    state_next = S_FIN;
                else if (count_reg == '0)
                begin
                    rej_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    d_raddr    = last_idx;
                    state_next = S_FL_UPD;
                end
            end

            // Append the byte, close and merge error flags into the last packet.
            S_FL_UPD:
            begin
                sum_x      = XW'(d_rdata.start) + XW'(d_rdata.len);
                state_next = S_FIN;
                if (hasb_reg && sum_x >= XW'(BUF_BYTES))
                    rej_next = 1'b1;
                else
                begin
                    if (hasb_reg)
                    begin
                        if (pay_reg)
                        begin
                            if ((d_rdata.state & ST_PAYLOAD) != '0)
                                cur_d.plen = d_rdata.plen + LW'(1);
                            else
                            begin
                                cur_d.pstart = LW'(sum_x);
                                cur_d.plen   = LW'(1);
                            end
                            cur_d.state = d_rdata.state | ST_PAYLOAD;
                        end
                        b_we      = 1'b1;
                        b_waddr   = AW'(sum_x);
                        b_wdata   = dbyte_reg;
                        cur_d.len = d_rdata.len + LW'(1);
                    end
                    if (close_reg)
                        cur_d.state = (cur_d.state & ~ST_PARTIAL) | ST_FULL;
                    cur_d.state = cur_d.state | {err_reg, 3'b000};
                    d_we    = 1'b1;
                    d_waddr = last_idx;
                    d_wdata = cur_d;
                end
            end

            S_CUT_RD:
            begin
                d_raddr    = last_idx;
                state_next = S_CUT_CHK;
            end

            // Split the last packet; a full queue first drops its oldest packet.
            S_CUT_CHK:
            begin
                state_next = S_FIN;
                if (d_rdata.len == '0 || cut_reg == '0)
                    rej_next = 1'b1;
                else if (XW'(d_rdata.len) < XW'(cut_reg))
                begin
                    cur_d.state = d_rdata.state | left_bits;
                    d_we    = 1'b1;
                    d_waddr = last_idx;
                    d_wdata = cur_d;
                end
                else if (count_reg >= CW'(MAX_PACKETS) && count_reg > CW'(1))
                    state_next = S_DROP;
                else
                begin
                    cur_d.state   = d_rdata.state | left_bits;
                    right_d.start = LW'(XW'(d_rdata.start) + XW'(cut_reg));
                    right_d.len   = LW'(XW'(d_rdata.len) - XW'(cut_reg));
                    right_d.state = rst_reg;
                    d_we    = 1'b1;
                    d_waddr = last_idx;
                    if (XW'(cut_reg) == XW'(d_rdata.len))
                        d_wdata = cur_d;
                    else if (count_reg >= CW'(MAX_PACKETS))
                        d_wdata = right_d;
                    else
                    begin
                        cur_d.len  = LW'(cut_reg);
                        d_wdata    = cur_d;
                        split_next = right_d;
                        state_next = S_CUT_NEW;
                    end
                end
            end

            S_CUT_NEW:
            begin
                d_we       = 1'b1;
                d_waddr    = DW'(count_reg);
                d_wdata    = split_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end

            S_RD_DESC:
            begin
                d_raddr    = '0;
                state_next = S_RD_CHK;
            end

            S_RD_CHK:
            begin
                sum_x      = XW'(d_rdata.start) + XW'(roff_reg);
                state_next = S_FIN;
                if (XW'(roff_reg) < XW'(d_rdata.len) && sum_x < XW'(BUF_BYTES))
                begin
                    b_raddr    = AW'(sum_x);
                    state_next = S_RD_BYTE;
                end
            end

            S_RD_BYTE:
            begin
                rbyte_next = b_rdata;
                state_next = S_FIN;
            end

            // Fetch the first and last descriptors for the result.
            S_FIN:
            begin
                d_raddr    = '0;
                state_next = S_FIN_FIRST;
            end

            S_FIN_FIRST:
            begin
                first_next = d_rdata;
                d_raddr    = last_idx;
                state_next = S_FIN_LAST;
            end

            S_FIN_LAST:
            begin
                done_next         = 1'b1;
                rejected_next     = rej_reg;
                read_byte_next    = rbyte_reg;
                packet_count_next = COUNT_W'(count_reg);
                if (count_reg == '0)
                begin
                    status_word_next  = '0;
                    last_state_next   = ST_FULL;
                    first_state_next  = '0;
                    has_first_next    = 1'b0;
                    first_start_next  = '0;
                    first_len_next    = '0;
                    first_pstart_next = '0;
                    first_plen_next   = '0;
                end
                else
                begin
                    status_word_next  = d_rdata.state;
                    last_state_next   = d_rdata.state;
                    first_state_next  = first_reg.state;
                    has_first_next    = (count_reg > CW'(1)) ||
                                        ((first_reg.state & ST_FULL) != '0);
                    first_start_next  = OFFS_W'(first_reg.start);
                    first_len_next    = LEN_W'(first_reg.len);
                    first_pstart_next = OFFS_W'(first_reg.pstart);
                    first_plen_next   = LEN_W'(first_reg.plen);
                end
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign done                = done_reg;
    assign status_word         = status_word_reg;
    assign rejected            = rejected_reg;
    assign packet_count        = packet_count_reg;
    assign last_state          = last_state_reg;
    assign first_state         = first_state_reg;
    assign has_first_packet    = has_first_reg;
    assign first_start         = first_start_reg;
    assign first_len           = first_len_reg;
    assign first_payload_start = first_pstart_reg;
    assign first_payload_len   = first_plen_reg;
    assign read_byte           = read_byte_reg;

endmodule

[hw/rtl/pbq_checker.sv]
// Port-level checker of the packet buffer queue and its bind.
`include "packet_buffer_queue_defines.svh"

module pbq_checker
    import pbq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [COUNT_W-1:0] packet_count,
    input logic [STATE_W-1:0] last_state,
    input logic [STATE_W-1:0] first_state,
    input logic               has_first_packet
);

    // An accepted item always makes the block busy.
    `PBQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    // A result is shown only once the block is ready for the next item.
    `PBQ_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

    // Results are single-cycle strobes.
    `PBQ_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")

    // An empty queue reports the fixed empty codes.
    `PBQ_ASSERT_NOW(a_empty_codes, done && packet_count == '0,
        last_state == ST_FULL && first_state == '0 && !has_first_packet,
        "empty queue reported wrong state codes")

    // With one packet, the first-packet flag follows its full bit.
    `PBQ_ASSERT_NOW(a_single_first, done && packet_count == COUNT_W'(1),
        has_first_packet == first_state[1], "first packet flag disagrees with state")

endmodule

bind packet_buffer_queue pbq_checker u_pbq_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the packet buffer queue with a built-in descriptor predictor.
`timescale 1ns / 100ps

module testbench;
    import pbq_pkg::*;

    localparam int BUF_BYTES   = 4096;
    localparam int MAX_PACKETS = 256;
    localparam int RANDOM_ITEMS = 830;

    // One input item, one port per field.
    typedef struct {
        op_t                op;
        logic               create;
        logic               close;
        logic               has_b;
        logic               pay;
        logic [BYTE_W-1:0]  data;
        logic [ERR_W-1:0]   err;
        logic [LEN_W-1:0]   cut;
        logic [STATE_W-1:0] lstate;
        logic [STATE_W-1:0] rstate;
        logic [OFFS_W-1:0]  roff;
    } pbq_item_t;

    // One result item.
    typedef struct {
        logic [STATE_W-1:0] status;
        logic               rej;
        logic [COUNT_W-1:0] count;
        logic [STATE_W-1:0] lst;
        logic [STATE_W-1:0] fst;
        logic               has_first;
        logic [OFFS_W-1:0]  fstart;
        logic [LEN_W-1:0]   flen;
        logic [OFFS_W-1:0]  fpstart;
        logic [LEN_W-1:0]   fplen;
        logic [BYTE_W-1:0]  rbyte;
    } pbq_result_t;

    // Directed row: an item plus an optional typed rejected flag and packet count.
    typedef struct {
        pbq_item_t          item;
        bit                 typed;
        logic               rej;
        logic [COUNT_W-1:0] count;
    } pbq_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0] operation = '0;
    logic cmd_create = 1'b0;
    logic cmd_close = 1'b0;
    logic has_byte = 1'b0;
    logic byte_is_payload = 1'b0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [ERR_W-1:0] error_bits = '0;
    logic [LEN_W-1:0] cut_offset = '0;
    logic [STATE_W-1:0] left_state = '0;
    logic [STATE_W-1:0] right_state = '0;
    logic [OFFS_W-1:0] read_offset = '0;
    logic done;
    logic [STATE_W-1:0] status_word;
    logic rejected;
    logic [COUNT_W-1:0] packet_count;
    logic [STATE_W-1:0] last_state;
    logic [STATE_W-1:0] first_state;
    logic has_first_packet;
    logic [OFFS_W-1:0] first_start;
    logic [LEN_W-1:0] first_len;
    logic [OFFS_W-1:0] first_payload_start;
    logic [LEN_W-1:0] first_payload_len;
    logic [BYTE_W-1:0] read_byte;

    packet_buffer_queue #(.BUF_BYTES(BUF_BYTES), .MAX_PACKETS(MAX_PACKETS)) dut (.*);

    always #1 clk = ~clk;

    // Shadow copy of the byte store and the descriptor queue.
    logic [7:0]         shadow_bytes [BUF_BYTES];
    int                 desc_start [MAX_PACKETS];
    int                 desc_len [MAX_PACKETS];
    int                 desc_pstart [MAX_PACKETS];
    int                 desc_plen [MAX_PACKETS];
    logic [STATE_W-1:0] desc_state [MAX_PACKETS];
    int                 held_pkts = 0;

    pbq_result_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    int refused_items = 0;
    int results_seen = 0;
    bit burst_mode = 1'b0;

    // Drop the oldest packet and slide bytes and descriptors to the front.
    function automatic void drop_oldest();
        int org;
        int tail;
        if (held_pkts == 0) return;
        if (held_pkts == 1) begin
            held_pkts = 0;
            return;
        end
        org = desc_start[1];
        tail = desc_start[held_pkts-1] + desc_len[held_pkts-1];
        if (tail > org && tail <= BUF_BYTES)
            for (int a = 0; a < tail - org; a++) shadow_bytes[a] = shadow_bytes[a+org];
        for (int i = 1; i < held_pkts; i++) begin
            desc_start[i-1]  = desc_start[i] >= org ? desc_start[i] - org : 0;
            desc_len[i-1]    = desc_len[i];
            desc_pstart[i-1] = desc_pstart[i] >= org ? desc_pstart[i] - org : 0;
            desc_plen[i-1]   = desc_plen[i];
            desc_state[i-1]  = desc_state[i];
        end
        held_pkts--;
    endfunction

    // Fill the last packet; returns the refusal flag.
    function automatic logic apply_fill(pbq_item_t it);
        int k;
        int pos;
        if (it.create) begin
            if (held_pkts >= MAX_PACKETS) drop_oldest();
            k = held_pkts;
            desc_start[k]  = k ? desc_start[k-1] + desc_len[k-1] : 0;
            desc_len[k]    = 0;
            desc_pstart[k] = 0;
            desc_plen[k]   = 0;
            desc_state[k]  = ST_PARTIAL;
            held_pkts++;
        end
        if (!(it.has_b || it.close || it.err != 0)) return 1'b0;
        if (held_pkts == 0) return 1'b1;
        k = held_pkts - 1;
        if (it.has_b) begin
            pos = desc_start[k] + desc_len[k];
            if (pos >= BUF_BYTES) return 1'b1;
            if (it.pay) begin
                if (desc_state[k] & ST_PAYLOAD) desc_plen[k]++;
                else begin
                    desc_pstart[k] = pos;
                    desc_plen[k] = 1;
                end
                desc_state[k] |= ST_PAYLOAD;
            end
            shadow_bytes[pos] = it.data;
            desc_len[k]++;
        end
        if (it.close) desc_state[k] = (desc_state[k] & ~ST_PARTIAL) | ST_FULL;
        desc_state[k] |= {it.err, 3'b000};
        return 1'b0;
    endfunction

    // Split the last packet at the given offset; returns the refusal flag.
    function automatic logic apply_cut(pbq_item_t it);
        int k;
        int len;
        int n;
        int at;
        logic [STATE_W-1:0] lbits;
        lbits = it.lstate | ST_FULL;
        if (held_pkts == 0) return 1'b1;
        k = held_pkts - 1;
        if (desc_len[k] == 0 || it.cut == 0) return 1'b1;
        if (desc_len[k] < it.cut) begin
            desc_state[k] |= lbits;
            return 1'b0;
        end
        if (held_pkts >= MAX_PACKETS && held_pkts > 1) drop_oldest();
        k = held_pkts - 1;
        desc_state[k] |= lbits;
        len = desc_len[k];
        if (it.cut == len) return 1'b0;
        at = desc_start[k] + it.cut;
        if (held_pkts >= MAX_PACKETS) n = k;
        else begin
            desc_len[k] = it.cut;
            n = held_pkts;
            held_pkts++;
        end
        desc_state[n]  = it.rstate;
        desc_start[n]  = at;
        desc_len[n]    = len - it.cut;
        desc_pstart[n] = 0;
        desc_plen[n]   = 0;
        return 1'b0;
    endfunction

    // Apply one item to the shadow queue and work out its result.
    function automatic pbq_result_t predict_queue(pbq_item_t it);
        pbq_result_t r;
        r.rej = 1'b0;
        r.rbyte = '0;
        case (it.op)
            OP_FILL: r.rej = apply_fill(it);
            OP_CUT: r.rej = apply_cut(it);
            OP_REMOVE: if (held_pkts == 0) r.rej = 1'b1; else drop_oldest();
            default:
                if (held_pkts == 0) r.rej = 1'b1;
                else if (it.roff < desc_len[0] && desc_start[0] + it.roff < BUF_BYTES)
                    r.rbyte = shadow_bytes[desc_start[0] + it.roff];
        endcase
        r.count = COUNT_W'(held_pkts);
        r.status = held_pkts ? desc_state[held_pkts-1] : '0;
        r.lst = held_pkts ? desc_state[held_pkts-1] : ST_FULL;
        r.fst = held_pkts ? desc_state[0] : '0;
        r.has_first = held_pkts > 1 || (held_pkts == 1 && (desc_state[0] & ST_FULL) != 0);
        r.fstart = held_pkts ? OFFS_W'(desc_start[0]) : '0;
        r.flen = held_pkts ? LEN_W'(desc_len[0]) : '0;
        r.fpstart = held_pkts ? OFFS_W'(desc_pstart[0]) : '0;
        r.fplen = held_pkts ? LEN_W'(desc_plen[0]) : '0;
        return r;
    endfunction

    function automatic pbq_item_t make_item(op_t op, int cr, int cl, int hb, int pay,
                                            int data, int err, int cut, int ls, int rs,
                                            int roff);
        pbq_item_t it;
        it.op = op; it.create = cr[0]; it.close = cl[0]; it.has_b = hb[0];
        it.pay = pay[0];
        it.data = BYTE_W'(data); it.err = ERR_W'(err); it.cut = LEN_W'(cut);
        it.lstate = STATE_W'(ls); it.rstate = STATE_W'(rs);
        it.roff = OFFS_W'(roff);
        return it;
    endfunction

    // Random item shaped by the current queue contents.
    function automatic pbq_item_t random_item();
        pbq_item_t it;
        int pick;
        int used;
        int lastlen;
        it = make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, 4096), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 4095));
        used = held_pkts ? desc_start[held_pkts-1] + desc_len[held_pkts-1] : 0;
        lastlen = held_pkts ? desc_len[held_pkts-1] : 0;
        pick = $urandom_range(0, 99);
        if (pick < 4) return it;
        if (held_pkts == 0 && pick < 85) begin
            it.op = OP_FILL;
            it.create = 1'b1;
        end else if (pick < 55 && (used < 300 || pick < 20)) begin
            it.op = OP_FILL;
            it.create = $urandom_range(0, 99) < 15;
            it.has_b = $urandom_range(0, 99) < 85;
            it.close = $urandom_range(0, 99) < 10;
            if ($urandom_range(0, 99) < 85) it.err = '0;
        end else if (pick < 70 || (pick < 80 && used >= 300)) begin
            it.op = OP_CUT;
            if ($urandom_range(0, 99) < 80) it.cut = LEN_W'($urandom_range(1, lastlen + 1));
        end else if (pick < 86 || held_pkts > 24 || used >= 300) begin
            it.op = OP_REMOVE;
        end else begin
            it.op = OP_READ;
            if (held_pkts && $urandom_range(0, 99) < 80 && desc_len[0] > 0)
                it.roff = OFFS_W'($urandom_range(0, desc_len[0] - 1));
        end
        return it;
    endfunction

    // Hand one item to the block and queue its expected result.
    task automatic send_item(pbq_item_t it, bit typed = 0, logic trej = 0,
                             logic [COUNT_W-1:0] tcount = '0);
        int gap;
        pbq_result_t r;
        if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= it.op;
        cmd_create <= it.create;
        cmd_close <= it.close;
        has_byte <= it.has_b;
        byte_is_payload <= it.pay;
        data_byte <= it.data;
        error_bits <= it.err;
        cut_offset <= it.cut;
        left_state <= it.lstate;
        right_state <= it.rstate;
        read_offset <= it.roff;
        do @(posedge clk); while (busy);
        r = predict_queue(it);
        if (typed) begin
            r.rej = trej;
            r.count = tcount;
        end
        refused_items += r.rej;
        items_sent++;
        pending_results.push_back(r);
    endtask

    function automatic void check_field(string name, int expd, int got);
        if (expd != got) begin
            $error("%s: expected %0d, got %0d", name, expd, got);
            errors++;
        end
    endfunction

    // Compare each result strobe with the oldest expectation.
    always @(posedge clk) begin
        pbq_result_t e;
        if (rst_n && done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("status_word", e.status, status_word);
                check_field("rejected", e.rej, rejected);
                check_field("packet_count", e.count, packet_count);
                check_field("last_state", e.lst, last_state);
                check_field("first_state", e.fst, first_state);
                check_field("has_first_packet", e.has_first, has_first_packet);
                check_field("first_start", e.fstart, first_start);
                check_field("first_len", e.flen, first_len);
                check_field("first_payload_start", e.fpstart, first_payload_start);
                check_field("first_payload_len", e.fplen, first_payload_len);
                check_field("read_byte", e.rbyte, read_byte);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        pbq_row_t rows[$];
        pbq_row_t row;
        int wait_cycles;

        // Directed rows: empty-queue refusals, byte extremes, cuts and reads.
        row.typed = 1; row.rej = 1'b1; row.count = '0;
        row.item = make_item(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4095); rows.push_back(row);
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 4, 127, 127, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 1, 1, 255, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 0, 0, 0, 15, 0, 0, 0, 0); rows.push_back(row);
        row.rej = 1'b0;
        row.item = make_item(OP_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.count = COUNT_W'(1);
        row.item = make_item(OP_FILL, 1, 0, 1, 1, 255, 0, 0, 0, 0, 0); rows.push_back(row);
        row.typed = 0;
        row.item = make_item(OP_FILL, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 1, 1, 8'hA5, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 1, 1, 8'h5A, 15, 0, 0, 0, 0); rows.push_back(row);
        row.typed = 1; row.rej = 1'b1;
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 0, 127, 127, 0); rows.push_back(row);
        row.typed = 0;
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 1, 0, 8'h3C, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 1, 1, 1, 8'hC3, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_FILL, 0, 0, 1, 0, 8'h81, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 1, 127, 0, 0); rows.push_back(row);
        row.item = make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 2, 0, 127, 0); rows.push_back(row);
        row.item = make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3); rows.push_back(row);
        row.item = make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4095); rows.push_back(row);
        row.item = make_item(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.item = make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1); rows.push_back(row);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].rej, rows[i].count);

        // Random traffic, with fills favoured while under 300 bytes are in use.
        for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item());

        // Empty the queue, then fill the descriptor queue with one-byte packets.
        while (held_pkts > 0)
            send_item(make_item(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int p = 0; p < MAX_PACKETS; p++)
            send_item(make_item(OP_FILL, 1, p % 2, 1, $urandom_range(0, 1),
                                $urandom_range(0, 255),
                                $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : 0,
                                0, 0, 0, 0));
        // Work on the full descriptor queue.
        send_item(make_item(OP_FILL, 0, 1, 1, 1, 8'hEE, 15, 0, 0, 0, 0));
        send_item(make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 16, 0, 0, 0));
        send_item(make_item(OP_CUT, 0, 0, 0, 0, 0, 0, 1, 7'h55, 7'h2A, 0));
        send_item(make_item(OP_FILL, 1, 0, 1, 1, 8'h11, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7));
        for (int i = 0; i < 6; i++) send_item(random_item());
        start <= 1'b0;

        // Drain, with a bound, then let the block settle.
        wait_cycles = 0;
        while (pending_results.size() > 0 && wait_cycles < 200_000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (pending_results.size() > 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("Sent %0d items (%0d refused), checked %0d results.",
                 items_sent, refused_items, results_seen);
        $display("Covered empty-queue refusals, cuts, reads, compaction and a full packet queue.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
